// File: sv/tdc_pkg.sv
package tdc_pkg;

    localparam int DESC_W      = 64;
    localparam int LEVEL_W     = 2;
    localparam int ADDR_W      = 48;
    localparam int SIZE_W      = 64;
    localparam int LO_ATTR_W   = 12;
    localparam int HI_ATTR_W   = 17;
    localparam int HI_ATTR_LSB = 47;
    localparam int PAGE_SHIFT  = 12;

    localparam int ADDR_BITS_DEFAULT = 48;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int GRAN_W     = 2;
    localparam int PS_W       = 3;

    localparam logic [0:0] REG_GRANULE   = 1'd0;
    localparam logic [0:0] REG_PHYS_SIZE = 1'd1;

    localparam logic [GRAN_W-1:0] GRAN_4K  = 2'd0;
    localparam logic [GRAN_W-1:0] GRAN_16K = 2'd2;
    localparam logic [PS_W-1:0]   PS_RESERVED = 3'd7;

    localparam logic [LEVEL_W-1:0] LEVEL_PAGE = 2'd3;

    // result codes
    localparam logic [1:0] KIND_SECTION = 2'd0;
    localparam logic [1:0] KIND_DESCEND = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_NO_BLOCK = 2'd1;
    localparam logic [1:0] ERR_GRANULE  = 2'd2;
    localparam logic [1:0] ERR_PS       = 2'd3;

    // queue between decode and run tracking
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        ITEM_END      = 3'd0,
        ITEM_ERR_PS   = 3'd1,
        ITEM_ERR_GRAN = 3'd2,
        ITEM_DESCEND  = 3'd3,
        ITEM_BLOCK    = 3'd4
    } t_item_kind;

    typedef struct packed {
        t_item_kind             kind;
        logic [ADDR_W-1:0]      address;
        logic [SIZE_W-1:0]      size;
        logic [LO_ATTR_W-1:0]   lower_attrs;
        logic [HI_ATTR_W-1:0]   upper_attrs;
    } t_item;

    typedef struct packed {
        logic [1:0]             kind;
        logic [1:0]             error_code;
        logic [ADDR_W-1:0]      address;
        logic [SIZE_W-1:0]      size;
        logic [LO_ATTR_W-1:0]   lower_attrs;
        logic [HI_ATTR_W-1:0]   upper_attrs;
    } t_result;

    // block or page size by granule and level
    function automatic logic [SIZE_W-1:0] block_size(input logic [GRAN_W-1:0] gran,
                                                     input logic [LEVEL_W-1:0] lvl);
        logic [SIZE_W-1:0] sz;
        sz = '0;
        if (gran == GRAN_4K) begin
            case (lvl)
                2'd0:    sz = SIZE_W'(64'h0000_0080_0000_0000);  // 512 GB
                2'd1:    sz = SIZE_W'(64'h0000_0000_4000_0000);  // 1 GB
                2'd2:    sz = SIZE_W'(64'h0000_0000_0020_0000);  // 2 MB
                default: sz = SIZE_W'(64'h0000_0000_0000_1000);  // 4 KB
            endcase
        end else begin
            case (lvl)
                2'd0:    sz = SIZE_W'(64'h0000_8000_0000_0000);  // 128 TB
                2'd1:    sz = SIZE_W'(64'h0000_0010_0000_0000);  // 64 GB
                2'd2:    sz = SIZE_W'(64'h0000_0000_0200_0000);  // 32 MB
                default: sz = SIZE_W'(64'h0000_0000_0000_4000);  // 16 KB
            endcase
        end
        return sz;
    endfunction

endpackage

// File: sv/tdc_front.sv
module tdc_front #(
    parameter int ADDR_BITS = tdc_pkg::ADDR_BITS_DEFAULT
) (
    input  logic [tdc_pkg::DESC_W-1:0]  i_descriptor,
    input  logic [tdc_pkg::LEVEL_W-1:0] i_level,
    input  logic [tdc_pkg::GRAN_W-1:0]  i_granule_code,
    input  logic [tdc_pkg::PS_W-1:0]    i_phys_size_code,
    output tdc_pkg::t_item              o_item
);
    import tdc_pkg::*;

    localparam int OA_TOP = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;

    logic              desc_valid;
    logic              desc_bit1;
    logic              is_end;
    logic [ADDR_W-1:0] oa_mask;

    // output address keeps bits OA_TOP-1 down to the page offset
    always_comb begin
        for (int i = 0; i < ADDR_W; i++) begin
            oa_mask[i] = (i >= PAGE_SHIFT) && (i < OA_TOP);
        end
    end

    assign desc_valid = i_descriptor[0];
    assign desc_bit1  = i_descriptor[1];
    // reserved level-3 encoding behaves like an invalid word
    assign is_end     = !desc_valid || ((i_level == LEVEL_PAGE) && !desc_bit1);

    always_comb begin
        o_item             = '0;
        o_item.address     = i_descriptor[ADDR_W-1:0] & oa_mask;
        o_item.size        = block_size(i_granule_code, i_level);
        o_item.lower_attrs = i_descriptor[LO_ATTR_W-1:0];
        o_item.upper_attrs = i_descriptor[HI_ATTR_LSB +: HI_ATTR_W];
        if (is_end) begin
            o_item.kind = ITEM_END;
        end else if (i_phys_size_code == PS_RESERVED) begin
            o_item.kind = ITEM_ERR_PS;
        end else if ((i_granule_code != GRAN_4K) && (i_granule_code != GRAN_16K)) begin
            o_item.kind = ITEM_ERR_GRAN;
        end else if (desc_bit1 && (i_level != LEVEL_PAGE)) begin
            o_item.kind = ITEM_DESCEND;
        end else begin
            o_item.kind = ITEM_BLOCK;
        end
    end

endmodule

// File: sv/tdc_queue.sv
module tdc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tdc_pkg::t_item  i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output tdc_pkg::t_item  o_item
);
    import tdc_pkg::*;

    t_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_PTR_W-1:0] n_wr_ptr;
    logic [Q_PTR_W-1:0] n_rd_ptr;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: sv/tdc_back.sv
module tdc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  tdc_pkg::t_item    i_item,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output tdc_pkg::t_result  o_result
);
    import tdc_pkg::*;

    logic                 r_run_pending;
    logic                 r_seen;
    logic [ADDR_W-1:0]    r_run_base;
    logic [SIZE_W-1:0]    r_run_length;
    logic [LO_ATTR_W-1:0] r_run_lo;
    logic [HI_ATTR_W-1:0] r_run_hi;
    logic                 r_out_valid;
    t_result              r_result;

    logic                 n_run_pending;
    logic                 n_seen;
    logic [ADDR_W-1:0]    n_run_base;
    logic [SIZE_W-1:0]    n_run_length;
    logic [LO_ATTR_W-1:0] n_run_lo;
    logic [HI_ATTR_W-1:0] n_run_hi;

    logic                 slot_free;
    logic [SIZE_W:0]      run_end;
    logic [SIZE_W:0]      len_sum;
    logic                 joins_run;
    logic                 res_valid;
    t_result              res;
    t_result              run_section;

    assign slot_free = !r_out_valid || !i_out_stall;
    assign o_pop     = i_q_valid && slot_free;

    assign run_end = {1'b0, {(SIZE_W - ADDR_W){1'b0}}, r_run_base} + {1'b0, r_run_length};
    assign len_sum = {1'b0, r_run_length} + {1'b0, i_item.size};

    // contiguous with no wrap of the run end, and identical attributes
    assign joins_run = r_run_pending && !run_end[SIZE_W]
                    && (run_end[SIZE_W-1:0] == {{(SIZE_W - ADDR_W){1'b0}}, i_item.address})
                    && (i_item.lower_attrs == r_run_lo)
                    && (i_item.upper_attrs == r_run_hi);

    always_comb begin
        run_section             = '0;
        run_section.kind        = KIND_SECTION;
        run_section.error_code  = ERR_NONE;
        run_section.address     = r_run_base;
        run_section.size        = r_run_length;
        run_section.lower_attrs = r_run_lo;
        run_section.upper_attrs = r_run_hi;
    end

    always_comb begin
        res_valid     = 1'b0;
        res           = '0;
        n_run_pending = r_run_pending;
        n_seen        = r_seen;
        n_run_base    = r_run_base;
        n_run_length  = r_run_length;
        n_run_lo      = r_run_lo;
        n_run_hi      = r_run_hi;
        unique case (i_item.kind)
            ITEM_END: begin
                if (!r_seen) begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_NO_BLOCK;
                end else if (r_run_pending) begin
                    res_valid     = 1'b1;
                    res           = run_section;
                    n_run_pending = 1'b0;
                end
            end
            ITEM_ERR_PS: begin
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_PS;
            end
            ITEM_ERR_GRAN: begin
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_GRANULE;
            end
            ITEM_DESCEND: begin
                res_valid   = 1'b1;
                res.kind    = KIND_DESCEND;
                res.address = i_item.address;
            end
            ITEM_BLOCK: begin
                n_seen = 1'b1;
                if (joins_run) begin
                    n_run_length = len_sum[SIZE_W] ? '1 : len_sum[SIZE_W-1:0];
                end else begin
                    if (r_run_pending) begin
                        res_valid = 1'b1;
                        res       = run_section;
                    end
                    n_run_pending = 1'b1;
                    n_run_base    = i_item.address;
                    n_run_length  = i_item.size;
                    n_run_lo      = i_item.lower_attrs;
                    n_run_hi      = i_item.upper_attrs;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_pending <= 1'b0;
            r_seen        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_run_pending <= n_run_pending;
                r_seen        <= n_seen;
            end
            if (slot_free) begin
                r_out_valid <= o_pop && res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_run_base   <= n_run_base;
            r_run_length <= n_run_length;
            r_run_lo     <= n_run_lo;
            r_run_hi     <= n_run_hi;
        end
        if (o_pop && res_valid) begin
            r_result <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

`ifndef SYNTHESIS
    a_pending_needs_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_pending |-> r_seen)
        else $error("run pending without any block seen");

    a_section_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_result.kind == KIND_SECTION)) |-> (r_result.size != '0))
        else $error("emitted section with zero size");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_result.kind == KIND_ERROR))
            |-> ((r_result.error_code != ERR_NONE) && (r_result.address == '0)
                 && (r_result.size == '0)))
        else $error("error result with stray fields");

    a_block_opens_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && (i_item.kind == ITEM_BLOCK)) |=> (!i_rst_n || r_run_pending))
        else $error("block word did not leave a pending run");
`endif

endmodule

// File: sv/translation_descriptor_coalescer.sv
// Translation descriptor coalescer: takes 64-bit translation-table words in walk order, each
// with its lookup level, and returns next-table addresses for table words, merged sections
// for runs of contiguous block or page words with equal attributes, and error codes for a
// reserved size code, an unsupported granule, or an end of walk before any block. A run is
// emitted when a word breaks it or when an invalid word ends the walk; its length saturates
// at all ones. Unless the output stalls, the block sustains one word per clock on the input:
// a decode stage classifies each word and writes it into a two-entry queue, and the run
// tracker drains one word per cycle with a single 64-bit end compare and length add, so
// throughput is set by that tracker. An accepted word goes from queue to output register,
// straight through when the queue ahead is empty and the output is free. The output register
// lets the input keep flowing while a result waits; a stalled output stops the tracker, and
// the input stalls once the queue fills. The user writes configuration over APB only while
// the block is idle (it does not check): granule code at byte address 0, size code at 4.
module translation_descriptor_coalescer #(
    parameter int ADDR_BITS = tdc_pkg::ADDR_BITS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tdc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tdc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tdc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    // descriptor words in
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [tdc_pkg::DESC_W-1:0]      i_descriptor,
    input  logic [tdc_pkg::LEVEL_W-1:0]     i_level,
    // result words out
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_kind,
    output logic [1:0]                      o_error_code,
    output logic [tdc_pkg::ADDR_W-1:0]      o_address,
    output logic [tdc_pkg::SIZE_W-1:0]      o_size,
    output logic [tdc_pkg::LO_ATTR_W-1:0]   o_lower_attrs,
    output logic [tdc_pkg::HI_ATTR_W-1:0]   o_upper_attrs
);
    import tdc_pkg::*;

    logic [GRAN_W-1:0] r_granule_code;
    logic [PS_W-1:0]   r_phys_size_code;

    logic     cfg_write;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;
    logic     in_accept;
    t_item    dec_item;
    t_item    q_item;
    t_result  result;

    // register bank, word index from paddr bit 2
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_granule_code   <= GRAN_4K;
            r_phys_size_code <= '0;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_GRANULE:   r_granule_code   <= pwdata[GRAN_W-1:0];
                REG_PHYS_SIZE: r_phys_size_code <= pwdata[PS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_GRANULE:   prdata = APB_DATA_W'(r_granule_code);
            REG_PHYS_SIZE: prdata = APB_DATA_W'(r_phys_size_code);
            default:       prdata = '0;
        endcase
    end

    // front: classify each word as it arrives
    tdc_front #(
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .i_descriptor     (i_descriptor),
        .i_level          (i_level),
        .i_granule_code   (r_granule_code),
        .i_phys_size_code (r_phys_size_code),
        .o_item           (dec_item)
    );

    // input stalls only on a full queue
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    tdc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_item  (dec_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // back: run tracking and the output register
    tdc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_item      (q_item),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    assign o_kind        = result.kind;
    assign o_error_code  = result.error_code;
    assign o_address     = result.address;
    assign o_size        = result.size;
    assign o_lower_attrs = result.lower_attrs;
    assign o_upper_attrs = result.upper_attrs;

endmodule

// File: sim/translation_descriptor_coalescer_test.sv
`timescale 1ns / 1ps

module translation_descriptor_coalescer_test;

    import tdc_pkg::*;

    // expected-result tracking: mirrors the run coalescing and holds what the
    // block still owes us, oldest first
    class coalesce_scoreboard;
        logic [GRAN_W-1:0]    granule;
        logic [PS_W-1:0]      phys_size;
        bit                   run_pending;
        bit                   any_block_seen;
        logic [ADDR_W-1:0]    run_base;
        logic [SIZE_W-1:0]    run_length;
        logic [LO_ATTR_W-1:0] run_lo;
        logic [HI_ATTR_W-1:0] run_hi;
        t_result              pending_results[$];
        int                   mismatch_count;

        function new();
            granule        = GRAN_4K;
            phys_size      = '0;
            run_pending    = 1'b0;
            any_block_seen = 1'b0;
            run_base       = '0;
            run_length     = '0;
            run_lo         = '0;
            run_hi         = '0;
            mismatch_count = 0;
        endfunction

        task flag_mismatch(input string msg);
            if (mismatch_count < 50) begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
            mismatch_count++;
        endtask

        function void set_register(input logic [0:0] idx, input logic [31:0] value);
            case (idx)
                REG_GRANULE:   granule = value[GRAN_W-1:0];
                REG_PHYS_SIZE: phys_size = value[PS_W-1:0];
                default: ;
            endcase
        endfunction

        // bytes covered by one block or page word
        function logic [SIZE_W-1:0] span_bytes(input logic [GRAN_W-1:0] gran,
                                              input logic [LEVEL_W-1:0] lvl);
            int sh;
            case (lvl)
                2'd0:    sh = (gran == GRAN_16K) ? 47 : 39;
                2'd1:    sh = (gran == GRAN_16K) ? 36 : 30;
                2'd2:    sh = (gran == GRAN_16K) ? 25 : 21;
                default: sh = (gran == GRAN_16K) ? 14 : 12;
            endcase
            return 64'd1 << sh;
        endfunction

        function void close_run();
            t_result r;
            r             = '0;
            r.kind        = KIND_SECTION;
            r.address     = run_base;
            r.size        = run_length;
            r.lower_attrs = run_lo;
            r.upper_attrs = run_hi;
            pending_results.push_back(r);
            run_pending = 1'b0;
        endfunction

        function void note_descriptor(input logic [DESC_W-1:0] d,
                                      input logic [LEVEL_W-1:0] lvl);
            t_result              r;
            logic [ADDR_W-1:0]    oa;
            logic [SIZE_W-1:0]    bsize;
            logic [SIZE_W-1:0]    run_end;
            logic [SIZE_W-1:0]    sum;
            logic [LO_ATTR_W-1:0] lo;
            logic [HI_ATTR_W-1:0] hi;
            r = '0;
            // invalid word, or reserved encoding at the page level: end of walk
            if (!d[0] || (lvl == LEVEL_PAGE && !d[1])) begin
                if (!any_block_seen) begin
                    r.kind       = KIND_ERROR;
                    r.error_code = ERR_NO_BLOCK;
                    pending_results.push_back(r);
                end else if (run_pending) begin
                    close_run();
                end
                return;
            end
            if (phys_size == PS_RESERVED) begin
                r.kind       = KIND_ERROR;
                r.error_code = ERR_PS;
                pending_results.push_back(r);
                return;
            end
            if (granule != GRAN_4K && granule != GRAN_16K) begin
                r.kind       = KIND_ERROR;
                r.error_code = ERR_GRANULE;
                pending_results.push_back(r);
                return;
            end
            oa = {d[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
            if (d[1] && lvl != LEVEL_PAGE) begin
                r.kind    = KIND_DESCEND;
                r.address = oa;
                pending_results.push_back(r);
                return;
            end
            bsize          = span_bytes(granule, lvl);
            lo             = d[LO_ATTR_W-1:0];
            hi             = d[DESC_W-1:HI_ATTR_LSB];
            any_block_seen = 1'b1;
            if (run_pending) begin
                run_end = {16'h0, run_base} + run_length;
                if (run_end >= {16'h0, run_base} && run_end == {16'h0, oa} &&
                    lo == run_lo && hi == run_hi) begin
                    sum        = run_length + bsize;
                    run_length = (sum < run_length) ? '1 : sum;
                    return;
                end
                close_run();
            end
            run_pending = 1'b1;
            run_base    = oa;
            run_length  = bsize;
            run_lo      = lo;
            run_hi      = hi;
        endfunction

        task check_result(input t_result got);
            t_result want;
            string   bad;
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result kind %0d address %h size %h",
                                        got.kind, got.address, got.size));
                return;
            end
            want = pending_results.pop_front();
            bad  = "";
            if (got.kind !== want.kind)
                bad = {bad, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
            if (got.error_code !== want.error_code)
                bad = {bad, $sformatf(" error_code %0d/%0d", got.error_code, want.error_code)};
            if (got.address !== want.address)
                bad = {bad, $sformatf(" address %h/%h", got.address, want.address)};
            if (got.size !== want.size)
                bad = {bad, $sformatf(" size %h/%h", got.size, want.size)};
            if (got.lower_attrs !== want.lower_attrs)
                bad = {bad, $sformatf(" lower_attrs %h/%h", got.lower_attrs, want.lower_attrs)};
            if (got.upper_attrs !== want.upper_attrs)
                bad = {bad, $sformatf(" upper_attrs %h/%h", got.upper_attrs, want.upper_attrs)};
            if (bad != "") begin
                flag_mismatch({"result field got/expected:", bad});
            end
        endtask
    endclass

    // clock, reset and every block input start at known values
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [DESC_W-1:0]     i_descriptor = '0;
    logic [LEVEL_W-1:0]    i_level = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [1:0]            o_kind;
    logic [1:0]            o_error_code;
    logic [ADDR_W-1:0]     o_address;
    logic [SIZE_W-1:0]     o_size;
    logic [LO_ATTR_W-1:0]  o_lower_attrs;
    logic [HI_ATTR_W-1:0]  o_upper_attrs;

    coalesce_scoreboard sb;

    // idle percentages per side, changed between phases
    int in_idle_pct = 0;
    int out_idle_pct = 0;
    int out_burst = 0;
    logic [GRAN_W-1:0] cur_granule = GRAN_4K;

    // random phases: granule, size code, word count, idle on each side
    // the last phase runs with no idling at all
    int phase_gran[7]  = '{0, 2, 1, 3, 2, 0, 2};
    int phase_ps[7]    = '{3, 0, 7, 2, 7, 5, 1};
    int phase_words[7] = '{350, 300, 60, 60, 60, 300, 450};
    int phase_in[7]    = '{20, 40, 25, 10, 25, 30, 0};
    int phase_out[7]   = '{30, 10, 25, 40, 25, 30, 0};

    translation_descriptor_coalescer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_descriptor  (i_descriptor),
        .i_level       (i_level),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_error_code  (o_error_code),
        .o_address     (o_address),
        .o_size        (o_size),
        .o_lower_attrs (o_lower_attrs),
        .o_upper_attrs (o_upper_attrs)
    );

    always #5 i_clk = ~i_clk;

    // result side stall: random bursts, updated on the falling edge
    always @(negedge i_clk) begin
        if (out_burst > 0) begin
            out_burst = out_burst - 1;
        end else if (out_idle_pct > 0 && $urandom_range(99) < out_idle_pct) begin
            out_burst = $urandom_range(1, 5);
        end
        i_out_stall <= (out_burst > 0);
    end

    // every result word taken at a rising edge goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(t_result'({o_kind, o_error_code, o_address, o_size,
                                       o_lower_attrs, o_upper_attrs}));
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // present one descriptor word, with an optional idle gap ahead of it,
    // and hold it until the block takes it
    task automatic send_descriptor(input logic [DESC_W-1:0] d, input logic [LEVEL_W-1:0] lvl);
        int gap;
        if (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
            gap = $urandom_range(1, 5);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_descriptor <= d;
        i_level      <= lvl;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_descriptor(d, lvl);
    endtask

    // apb write, then read the register back
    task automatic write_register(input logic [0:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_register(idx, value);
        if (idx == REG_GRANULE) begin
            cur_granule = value[GRAN_W-1:0];
        end
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== value) begin
            sb.flag_mismatch($sformatf("register %0d reads %h, wrote %h", idx, prdata, value));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // drop valid, wait out every expected word and then wait on for words
    // that make no result, so that registers can be written safely
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // one walk: optional table words down to the leaf level, then a run of
    // block or page words, mostly contiguous with equal attributes, then
    // usually an end word (invalid, or the reserved page-level encoding)
    task automatic send_walk(output int n);
        int                leaf;
        int                lvl;
        logic [63:0]       span;
        logic [63:0]       addr;
        logic [15:0]       hi_bits;
        logic [9:0]        lo_bits;
        logic [DESC_W-1:0] d;
        n    = 0;
        leaf = ($urandom_range(3) == 0) ? $urandom_range(1) : $urandom_range(2, 3);
        for (lvl = 0; lvl < leaf; lvl++) begin
            if ($urandom_range(3) != 0) begin
                send_descriptor({62'(rand64() >> 2), 2'b11}, LEVEL_W'(lvl));
                n++;
            end
        end
        span    = sb.span_bytes(cur_granule, LEVEL_W'(leaf));
        addr    = rand64() & 64'h0000_FFFF_FFFF_FFFF & ~(span - 1);
        hi_bits = 16'($urandom);
        lo_bits = 10'($urandom);
        repeat ($urandom_range(1, 10)) begin
            // occasional break in the run: new base or new attributes
            if ($urandom_range(9) == 0) begin
                addr = rand64() & 64'h0000_FFFF_FFFF_FFFF & ~(span - 1);
            end
            if ($urandom_range(9) == 0) begin
                lo_bits = 10'($urandom);
            end
            d = {hi_bits, addr[47:12], lo_bits, (leaf == 3) ? 2'b11 : 2'b01};
            send_descriptor(d, LEVEL_W'(leaf));
            n++;
            addr = addr + span;
            if (addr[63:48] != 16'h0) begin
                addr = '0;
            end
        end
        case ($urandom_range(9))
            0, 1: ;  // walk runs straight into the next one
            2, 3: begin
                send_descriptor({62'(rand64() >> 2), 2'b01}, LEVEL_PAGE);
                n++;
            end
            default: begin
                send_descriptor({63'(rand64() >> 1), 1'b0}, LEVEL_W'($urandom_range(3)));
                n++;
            end
        endcase
    endtask

    task automatic run_random(input int count);
        int sent;
        int n;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 15) begin
                // noise: any word at any level
                send_descriptor(rand64(), LEVEL_W'($urandom_range(3)));
                sent++;
            end else begin
                send_walk(n);
                sent += n;
            end
        end
    endtask

    initial begin
        int waited;
        sb = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, 4KB granule
        write_register(REG_GRANULE, 32'(GRAN_4K));
        write_register(REG_PHYS_SIZE, 32'd0);
        in_idle_pct  = 25;
        out_idle_pct = 25;
        send_descriptor(64'h0, 2'd0);                    // end before any block
        send_descriptor(64'h1, LEVEL_PAGE);              // reserved page encoding, no block yet
        send_descriptor('1, 2'd0);                       // table word, all bits set
        send_descriptor(64'h3, 2'd2);                    // table word, address zero
        send_descriptor(64'h0000_0000_4000_0701, 2'd1);  // 1GB block starts a run
        send_descriptor(64'h0000_0000_8000_0701, 2'd1);  // contiguous, same attributes
        send_descriptor(64'h0000_0000_C000_0703, LEVEL_PAGE);  // attributes differ
        send_descriptor(64'h0000_0000_C000_1703, LEVEL_PAGE);  // contiguous page
        send_descriptor(64'h0000_0000_C000_2702, 2'd3);  // invalid word flushes the run
        send_descriptor(64'h0, 2'd1);                    // nothing pending, no result
        send_descriptor(64'hFFFF_FF80_0000_0FFD, 2'd0);  // top block, upper attributes all set
        send_descriptor(64'h1, 2'd2);                    // run end at the top of the space
        send_descriptor(64'h0000_0000_0020_0001, 2'd2);
        send_descriptor(64'h0000_0000_0000_0005, LEVEL_PAGE);  // reserved page encoding ends
        send_descriptor(64'h8000_1234_5678_9003, 2'd1);
        settle();

        // directed, 16KB granule with the largest blocks
        write_register(REG_GRANULE, 32'(GRAN_16K));
        write_register(REG_PHYS_SIZE, 32'd6);
        send_descriptor(64'h1, 2'd0);                    // 128TB block at zero
        send_descriptor(64'h0000_8000_0000_0001, 2'd0);  // contiguous, address bit 47 differs
        send_descriptor(64'h0000_0000_0000_4003, LEVEL_PAGE);
        send_descriptor(64'h0000_0000_0000_8003, LEVEL_PAGE);
        send_descriptor(64'h0, 2'd0);
        settle();

        // random phases across granule and size settings, errors among them
        for (int p = 0; p < 7; p++) begin
            write_register(REG_GRANULE, 32'(phase_gran[p]));
            write_register(REG_PHYS_SIZE, 32'(phase_ps[p]));
            in_idle_pct  = phase_in[p];
            out_idle_pct = phase_out[p];
            run_random(phase_words[p]);
            if (p < 6) begin
                settle();
            end
        end

        // drain, then give stray results time to show up
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        waited = 0;
        while (sb.pending_results.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (sb.pending_results.size() != 0) begin
            sb.flag_mismatch($sformatf("%0d results never arrived", sb.pending_results.size()));
        end
        if (sb.mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
